### design/assert_macros.svh
// Concurrent assertion helpers, sampled on clk and masked during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define CHECK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a consequent holds in the cycle after its antecedent.
`define CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/tgahp_pkg.sv
`default_nettype none
package tgahp_pkg;

  // Header layout
  localparam logic [4:0] HEADER_BYTES  = 5'd18;
  localparam logic [4:0] IDX_WIDTH_LO  = 5'd12;
  localparam logic [4:0] IDX_WIDTH_HI  = 5'd13;
  localparam logic [4:0] IDX_HEIGHT_LO = 5'd14;
  localparam logic [4:0] IDX_HEIGHT_HI = 5'd15;
  localparam logic [4:0] IDX_ORIENT    = 5'd17;

  // Orientation byte codes from the file
  localparam logic [7:0] CODE_BU_RL = 8'd24;
  localparam logic [7:0] CODE_TD_LR = 8'd40;
  localparam logic [7:0] CODE_BU_LR = 8'd8;
  localparam logic [7:0] CODE_TD_RL = 8'd56;

  // Internal scan modes
  localparam logic [2:0] ORIENT_NONE  = 3'd0;
  localparam logic [2:0] ORIENT_BU_RL = 3'd1;
  localparam logic [2:0] ORIENT_TD_LR = 3'd2;
  localparam logic [2:0] ORIENT_BU_LR = 3'd3;
  localparam logic [2:0] ORIENT_TD_RL = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } result_t;

  function automatic logic [2:0] orient_decode(input logic [7:0] code);
    logic [2:0] m;
    case (code)
      CODE_BU_RL: m = ORIENT_BU_RL;
      CODE_TD_LR: m = ORIENT_TD_LR;
      CODE_BU_LR: m = ORIENT_BU_LR;
      CODE_TD_RL: m = ORIENT_TD_RL;
      default:    m = ORIENT_NONE;
    endcase
    return m;
  endfunction

  function automatic logic bottom_up(input logic [2:0] m);
    return (m == ORIENT_BU_RL) || (m == ORIENT_BU_LR);
  endfunction

  function automatic logic right_left(input logic [2:0] m);
    return (m == ORIENT_BU_RL) || (m == ORIENT_TD_RL);
  endfunction

endpackage
`default_nettype wire

### design/tgahp_parser.sv
`default_nettype none
module tgahp_parser
  import tgahp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  output logic            res_valid,
  output result_t         res
);

  logic [4:0]  header_index, header_index_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [2:0]  orient_mode, orient_mode_next;
  logic [15:0] row_pos, row_pos_next;
  logic [15:0] col_pos, col_pos_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] partial_pixel, partial_pixel_next;
  logic        pixels_done, pixels_done_next;

  logic [2:0]  mode;
  logic        up, rl;
  logic [15:0] width_m1, height_m1, col_end, row_end;

  assign width_m1  = width_reg - 16'd1;
  assign height_m1 = height_reg - 16'd1;
  assign mode      = orient_decode(data_byte);
  assign up        = bottom_up(orient_mode);
  assign rl        = right_left(orient_mode);
  assign col_end   = rl ? 16'd0 : width_m1;
  assign row_end   = up ? 16'd0 : height_m1;

  // Advance parser state for one accepted byte
  always_comb begin
    header_index_next  = header_index;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    orient_mode_next   = orient_mode;
    row_pos_next       = row_pos;
    col_pos_next       = col_pos;
    byte_in_pixel_next = byte_in_pixel;
    partial_pixel_next = partial_pixel;
    pixels_done_next   = pixels_done;
    res_valid          = 1'b0;
    res                = '0;

    if (accept && first_byte) begin
      header_index_next  = '0;
      orient_mode_next   = ORIENT_NONE;
      byte_in_pixel_next = '0;
      partial_pixel_next = '0;
      pixels_done_next   = 1'b0;
    end

    if (accept && !pixels_done_next) begin
      if (header_index_next < HEADER_BYTES) begin
        header_index_next = header_index_next + 5'd1;
        if (header_index_next == IDX_WIDTH_LO + 5'd1) begin
          width_reg_next[7:0] = data_byte;
        end else if (header_index_next == IDX_WIDTH_HI + 5'd1) begin
          width_reg_next[15:8] = data_byte;
        end else if (header_index_next == IDX_HEIGHT_LO + 5'd1) begin
          height_reg_next[7:0] = data_byte;
        end else if (header_index_next == IDX_HEIGHT_HI + 5'd1) begin
          height_reg_next[15:8] = data_byte;
        end else if (header_index_next == IDX_ORIENT + 5'd1) begin
          orient_mode_next = mode;
          res_valid        = 1'b1;
          if (mode == ORIENT_NONE) begin
            pixels_done_next = 1'b1;
            res.result_kind  = KIND_ERROR;
          end else begin
            row_pos_next       = bottom_up(mode) ? height_m1 : 16'd0;
            col_pos_next       = right_left(mode) ? width_m1 : 16'd0;
            byte_in_pixel_next = '0;
            partial_pixel_next = '0;
            if (width_reg == 16'd0 || height_reg == 16'd0) begin
              pixels_done_next = 1'b1;
            end
            res.result_kind = KIND_HEADER;
          end
        end
      end else if (byte_in_pixel_next != 2'd3) begin
        // Collect blue, green, red
        unique case (byte_in_pixel_next)
          2'd0:    partial_pixel_next[7:0]   = data_byte;
          2'd1:    partial_pixel_next[15:8]  = data_byte;
          default: partial_pixel_next[23:16] = data_byte;
        endcase
        byte_in_pixel_next = byte_in_pixel_next + 2'd1;
      end else begin
        // Emit pixel and step the scan position
        res_valid          = 1'b1;
        res.result_kind    = KIND_PIXEL;
        res.row            = row_pos;
        res.col            = col_pos;
        res.blue           = partial_pixel[7:0];
        res.green          = partial_pixel[15:8];
        res.red            = partial_pixel[23:16];
        res.alpha          = data_byte;
        byte_in_pixel_next = '0;
        partial_pixel_next = '0;
        if (col_pos == col_end) begin
          if (row_pos == row_end) begin
            pixels_done_next = 1'b1;
          end else begin
            row_pos_next = up ? row_pos - 16'd1 : row_pos + 16'd1;
            col_pos_next = rl ? width_m1 : 16'd0;
          end
        end else begin
          col_pos_next = rl ? col_pos - 16'd1 : col_pos + 16'd1;
        end
      end
    end

    res.image_width  = width_reg_next;
    res.image_height = height_reg_next;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_index  <= '0;
      width_reg     <= '0;
      height_reg    <= '0;
      orient_mode   <= ORIENT_NONE;
      row_pos       <= '0;
      col_pos       <= '0;
      byte_in_pixel <= '0;
      partial_pixel <= '0;
      pixels_done   <= 1'b1;
    end else begin
      header_index  <= header_index_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      orient_mode   <= orient_mode_next;
      row_pos       <= row_pos_next;
      col_pos       <= col_pos_next;
      byte_in_pixel <= byte_in_pixel_next;
      partial_pixel <= partial_pixel_next;
      pixels_done   <= pixels_done_next;
    end
  end

endmodule
`default_nettype wire

### design/tgahp_out_buf.sv
`default_nettype none
module tgahp_out_buf
  import tgahp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire result_t  push_data,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output result_t       head
);

  result_t    slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/tga_header_and_pixel_placer_core.sv
// A result enters the result buffer at the clock edge that accepts the byte that completes it.
// Throughput: one byte per cycle while in_stall is low; the parser state updates in the same cycle.
// A two-entry result buffer parts the sides; stall rises only when both entries wait.
// Reset (rst, synchronous): parser idles until a byte flagged first_byte; buffer empties.
`default_nettype none
`include "assert_macros.svh"
module tga_header_and_pixel_placer_core
  import tgahp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [15:0]      row,
  output logic [15:0]      col,
  output logic [7:0]       blue,
  output logic [7:0]       green,
  output logic [7:0]       red,
  output logic [7:0]       alpha,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height
);

  logic    in_accept, out_accept, res_valid, buf_full;
  result_t res, head;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = buf_full;

  tgahp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  tgahp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_accept),
    .full      (buf_full),
    .not_empty (out_valid),
    .head      (head)
  );

  // Drive result fields from the buffer head
  assign result_kind  = head.result_kind;
  assign row          = head.row;
  assign col          = head.col;
  assign blue         = head.blue;
  assign green        = head.green;
  assign red          = head.red;
  assign alpha        = head.alpha;
  assign image_width  = head.image_width;
  assign image_height = head.image_height;

  `CHECK_ALWAYS(a_stall_needs_waiting, !in_stall || out_valid)
  `CHECK_ALWAYS(a_kind_legal, !out_valid || result_kind != 2'd3)
  `CHECK_ALWAYS(a_header_no_position,
    !out_valid || result_kind == KIND_PIXEL || (row == 16'd0 && col == 16'd0))
  `CHECK_NEXT(a_full_stall_holds_full, in_stall && out_stall, in_stall)

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tgahp_pkg::*;

  localparam int RANDOM_BYTES = 1500;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'h00;
  logic first_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [15:0] row;
  logic [15:0] col;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic [15:0] image_width;
  logic [15:0] image_height;

  tga_header_and_pixel_placer_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .row(row),
    .col(col),
    .blue(blue),
    .green(green),
    .red(red),
    .alpha(alpha),
    .image_width(image_width),
    .image_height(image_height)
  );

  // Predicted parser state
  logic [4:0] hdr_count = '0;
  logic [15:0] img_w = '0;
  logic [15:0] img_h = '0;
  logic [2:0] scan_mode = ORIENT_NONE;
  logic [15:0] cur_row = '0;
  logic [15:0] cur_col = '0;
  logic [1:0] pix_bytes = '0;
  logic [23:0] pix_acc = '0;
  logic parse_idle = 1'b1;

  result_t due_results[$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;
  logic [7:0] scan_codes[4] = '{CODE_BU_RL, CODE_TD_LR, CODE_BU_LR, CODE_TD_RL};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the predicted parser by one byte and queue any result it causes
  function automatic void place_byte(input logic [7:0] b, input logic f);
    result_t r;
    logic [4:0] idx;
    logic up;
    logic rl;
    logic [15:0] col_last;
    logic [15:0] row_last;
    r = '0;
    if (f) begin
      hdr_count = '0;
      scan_mode = ORIENT_NONE;
      pix_bytes = '0;
      pix_acc = '0;
      parse_idle = 1'b0;
    end
    if (parse_idle) return;

    // Header bytes
    if (hdr_count < HEADER_BYTES) begin
      idx = hdr_count;
      hdr_count = hdr_count + 5'd1;
      case (idx)
        IDX_WIDTH_LO:  img_w[7:0] = b;
        IDX_WIDTH_HI:  img_w[15:8] = b;
        IDX_HEIGHT_LO: img_h[7:0] = b;
        IDX_HEIGHT_HI: img_h[15:8] = b;
        IDX_ORIENT: begin
          case (b)
            CODE_BU_RL: scan_mode = ORIENT_BU_RL;
            CODE_TD_LR: scan_mode = ORIENT_TD_LR;
            CODE_BU_LR: scan_mode = ORIENT_BU_LR;
            CODE_TD_RL: scan_mode = ORIENT_TD_RL;
            default:    scan_mode = ORIENT_NONE;
          endcase
          r.image_width = img_w;
          r.image_height = img_h;
          if (scan_mode == ORIENT_NONE) begin
            parse_idle = 1'b1;
            r.result_kind = KIND_ERROR;
          end else begin
            up = (scan_mode == ORIENT_BU_RL) || (scan_mode == ORIENT_BU_LR);
            rl = (scan_mode == ORIENT_BU_RL) || (scan_mode == ORIENT_TD_RL);
            cur_row = up ? img_h - 16'd1 : 16'd0;
            cur_col = rl ? img_w - 16'd1 : 16'd0;
            pix_bytes = '0;
            pix_acc = '0;
            if (img_w == 16'd0 || img_h == 16'd0) parse_idle = 1'b1;
            r.result_kind = KIND_HEADER;
          end
          due_results.push_back(r);
        end
        default: ;
      endcase
      return;
    end

    // Collect blue, green, red
    if (pix_bytes < 2'd3) begin
      pix_acc[8*pix_bytes +: 8] = b;
      pix_bytes = pix_bytes + 2'd1;
      return;
    end

    // Alpha completes the pixel
    r.result_kind = KIND_PIXEL;
    r.row = cur_row;
    r.col = cur_col;
    r.blue = pix_acc[7:0];
    r.green = pix_acc[15:8];
    r.red = pix_acc[23:16];
    r.alpha = b;
    r.image_width = img_w;
    r.image_height = img_h;
    due_results.push_back(r);
    pix_bytes = '0;
    pix_acc = '0;

    // Step to the next position in scan order
    up = (scan_mode == ORIENT_BU_RL) || (scan_mode == ORIENT_BU_LR);
    rl = (scan_mode == ORIENT_BU_RL) || (scan_mode == ORIENT_TD_RL);
    col_last = rl ? 16'd0 : img_w - 16'd1;
    row_last = up ? 16'd0 : img_h - 16'd1;
    if (cur_col == col_last) begin
      if (cur_row == row_last) begin
        parse_idle = 1'b1;
      end else begin
        cur_row = up ? cur_row - 16'd1 : cur_row + 16'd1;
        cur_col = rl ? img_w - 16'd1 : 16'd0;
      end
    end else begin
      cur_col = rl ? cur_col - 16'd1 : cur_col + 16'd1;
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Send one request; hold it until accepted, then predict
  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    gap = in_idle_on ? gap_len() : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    first_byte = f;
    do @(posedge clk); while (in_stall);
    place_byte(b, f);
    bytes_sent++;
  endtask

  task automatic send_bytes(input int n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // Header with random filler in the unused bytes
  task automatic send_header(input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] code);
    logic [4:0] idx;
    logic [7:0] b;
    for (idx = 0; idx < HEADER_BYTES; idx++) begin
      case (idx)
        IDX_WIDTH_LO:  b = w[7:0];
        IDX_WIDTH_HI:  b = w[15:8];
        IDX_HEIGHT_LO: b = h[7:0];
        IDX_HEIGHT_HI: b = h[15:8];
        IDX_ORIENT:    b = code;
        default:       b = 8'($urandom);
      endcase
      send_byte(b, idx == 5'd0);
    end
  endtask

  // Drop valid and wait until every predicted result has come
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_idle_before_first();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    send_bytes(6);
  endtask

  task automatic test_scan_orders();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    foreach (scan_codes[i]) begin
      send_header(16'd3, 16'd2, scan_codes[i]);
      send_bytes(24);
    end
    // Pixel byte extremes
    send_header(16'd2, 16'd2, CODE_TD_LR);
    repeat (4) send_byte(8'hFF, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
    send_bytes(8);
  endtask

  task automatic test_bad_orient();
    send_header(16'd2, 16'd2, 8'h00);
    send_bytes(8);
    send_header(16'd1, 16'd1, 8'hFF);
    send_bytes(4);
    send_header(16'd1, 16'd1, CODE_BU_RL + 8'd1);
  endtask

  task automatic test_zero_size();
    send_header(16'd0, 16'd3, CODE_TD_LR);
    send_bytes(8);
    send_header(16'd3, 16'd0, CODE_BU_RL);
    send_bytes(8);
  endtask

  task automatic test_restart();
    // Restart in mid pixel, then in mid header
    send_header(16'd2, 16'd2, CODE_TD_LR);
    send_bytes(6);
    send_header(16'd1, 16'd1, CODE_BU_LR);
    send_bytes(2);
    send_byte(8'($urandom), 1'b1);
    send_bytes(7);
    send_header(16'd2, 16'd1, CODE_TD_RL);
    send_bytes(8);
  endtask

  task automatic test_trailing_bytes();
    send_header(16'd1, 16'd2, CODE_TD_RL);
    send_bytes(18);
  endtask

  task automatic test_max_size();
    send_header(16'hFFFF, 16'hFFFF, CODE_BU_RL);
    send_bytes(40);
    send_header(16'hFFFF, 16'hFFFF, CODE_TD_LR);
    send_bytes(20);
  endtask

  task automatic test_random_files();
    int base;
    int pick;
    int w;
    int h;
    int n;
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      in_idle_on = ($urandom_range(0, 4) != 0);
      out_idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // Well-formed file, sometimes short or with trailing bytes
        if ($urandom_range(0, 19) == 0) begin
          w = $urandom_range(1, 65535);
          h = $urandom_range(1, 65535);
          n = $urandom_range(0, 48);
        end else begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 5);
          n = 4 * w * h;
          case ($urandom_range(0, 5))
            0: n = n + $urandom_range(1, 9);
            1: n = $urandom_range(0, n - 1);
            default: ;
          endcase
        end
        send_header(16'(w), 16'(h), scan_codes[$urandom_range(0, 3)]);
        send_bytes(n);
      end else if (pick < 88) begin
        send_header(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)), 8'($urandom));
        send_bytes($urandom_range(0, 12));
      end else if (pick < 94) begin
        send_byte(8'($urandom), 1'b1);
        send_bytes($urandom_range(0, 16));
      end else begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 65535);
        h = (w == 0) ? $urandom_range(0, 65535) : 0;
        send_header(16'(w), 16'(h), scan_codes[$urandom_range(0, 3)]);
        send_bytes($urandom_range(0, 8));
      end
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  // Result side: random stalls at the falling edge
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (out_idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d", result_kind));
      end else begin
        want = due_results.pop_front();
        compare_field("result_kind", 16'(result_kind), 16'(want.result_kind));
        compare_field("row", row, want.row);
        compare_field("col", col, want.col);
        compare_field("blue", 16'(blue), 16'(want.blue));
        compare_field("green", 16'(green), 16'(want.green));
        compare_field("red", 16'(red), 16'(want.red));
        compare_field("alpha", 16'(alpha), 16'(want.alpha));
        compare_field("image_width", image_width, want.image_width);
        compare_field("image_height", image_height, want.image_height);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tga_header_and_pixel_placer_core: mismatch");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_idle_before_first();
    test_scan_orders();
    test_bad_orient();
    test_zero_size();
    test_restart();
    test_trailing_bytes();
    test_max_size();
    drain_results();
    test_random_files();
    drain_results();
    if (mismatch_count == 0) begin
      $display("tga_header_and_pixel_placer_core: match");
    end else begin
      $display("tga_header_and_pixel_placer_core: mismatch");
    end
    $finish;
  end

endmodule
